// ===== hw/rtl/frm_pkg.sv =====
// frm_pkg: shared types and constants of the frame rate meter
// no dependencies; imported by frm_div and frame_rate_meter

package frm_pkg;

  // request codes of the input channel
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // configuration register indexes (byte address 4*index)
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_FIXED_DELTA = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;

  // reset values of the registers
  localparam logic [15:0] TARGET_RST = 16'd15360;
  localparam logic [19:0] FIXED_DELTA_RST = 20'd16667;
  localparam logic [7:0] WARMUP_RST = 8'd3;

  // period guard and rate conversion
  localparam logic [19:0] DELTA_MIN = 20'd100;
  localparam logic [31:0] DELTA_LIMIT = 32'd1000000;
  localparam int unsigned RATE_NUM_W = 28;
  localparam logic [RATE_NUM_W-1:0] RATE_NUM = 28'd256000000;
  localparam logic [15:0] RATE_FLOOR = 16'd256;
  localparam logic [15:0] RATE_SAT = 16'hFFFF;

  // floor(y / 5) = (y * HI_RECIP) >> HI_SHIFT, exact for y below 2^19
  localparam int unsigned HI_MUL_W = 19;
  localparam logic [HI_MUL_W-1:0] HI_RECIP = 19'd419431;
  localparam int unsigned HI_SHIFT = 21;
  localparam int unsigned HI_W = 17;

  // divisor width of the shared divider (a period or a sample count)
  localparam int unsigned DSR_W = 20;

  localparam int unsigned SAMPLES_DEF = 16;

  typedef struct packed {
    logic        req_type;
    logic [31:0] time_us;
  } frm_in_t;

  typedef struct packed {
    logic [19:0] delta_time_us;
    logic [15:0] current_fps_q8;
    logic        in_warmup;
  } frm_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frm_div_sts_t;

endpackage

// ===== hw/rtl/frm_div.sv =====
// frm_div: restoring divider, one quotient bit per cycle
// depends on frm_pkg (frm_div_sts_t, DSR_W)

module frm_div
  import frm_pkg::*;
#(
  parameter int unsigned DVD_W = 28,
  parameter int unsigned DVS_W = DSR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output frm_div_sts_t     sts,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dsr_r, dsr_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/frame_rate_meter.sv =====
// frame_rate_meter: frame period and averaged frame rate meter
// depends on frm_pkg and frm_div
//
// Each input transfer is a frame-start event with a microsecond timestamp, or a
// measurement reset. Reset events and warm-up frames go straight to ST_FIN. A
// measured frame runs two divisions on one shared restoring divider, one quotient
// bit per cycle: 256e6 / period, then the sum of ring samples / sample count.
// DIV_W is 28 for SAMPLES up to 4095. A period of 100 us or less after the guard
// (only a fallback period can be) skips the first division. in_stall is high
// while an event is worked on; the result sits in an output register, so the
// next event is taken while it waits. The user must make configuration writes
// between events, to take effect on later events; the block does not enforce it.

module frame_rate_meter
  import frm_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  frm_in_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output frm_out_t              out_data,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned CNT_W  = $clog2(SAMPLES + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(SAMPLES + 1);
  localparam int unsigned DIV_W  = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MEAS = 6'b000010,
    ST_DIVR = 6'b000100,
    ST_PUSH = 6'b001000,
    ST_DIVM = 6'b010000,
    ST_FIN  = 6'b100000
  } frm_state_t;

  // configuration registers
  logic [15:0] target_r;
  logic [19:0] fixed_delta_r;
  logic [7:0]  warmup_r;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // measurement state
  frm_state_t        state_r, state_nxt;
  logic [31:0]       last_time_r, last_time_nxt;
  logic [8:0]        frames_r, frames_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [19:0]       delta_r, delta_nxt;
  logic [15:0]       rate_r, rate_nxt;
  logic              warm_r, warm_nxt;
  logic              out_valid_r, out_valid_nxt;
  frm_out_t          out_data_r, out_data_nxt;
  logic [2*HI_MUL_W-1:0] hi_prod_r, hi_prod_nxt;

  // sample ring
  logic [15:0] ring_mem [SAMPLES];
  logic [15:0] ring_rd_r;
  logic        ring_re;
  logic        ring_we;

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DSR_W-1:0] div_dsr;
  frm_div_sts_t     div_sts;
  logic [DIV_W-1:0] div_quo;

  // datapath helpers
  logic [8:0]        frame_cnt;
  logic [8:0]        warm_cap;
  logic [31:0]       meas_d;
  logic [19:0]       meas_delta;
  logic [20:0]       tgt_x21;
  logic [HI_MUL_W-1:0] tgt_q4;
  logic [HI_W-1:0]   rate_hi_lim;
  logic              delta_small;
  logic              ring_full;
  logic [DIV_W-1:0]  rate_lo;
  logic [DIV_W-1:0]  rate_cl;
  logic [15:0]       inst_rate;
  logic [15:0]       mean_rate;
  logic              out_load;

  frm_div #(
    .DVD_W (DIV_W),
    .DVS_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= TARGET_RST;
      fixed_delta_r <= FIXED_DELTA_RST;
      warmup_r      <= WARMUP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET:      target_r      <= cfg_pwdata[15:0];
        REG_FIXED_DELTA: fixed_delta_r <= cfg_pwdata[19:0];
        REG_WARMUP:      warmup_r      <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET:      cfg_prdata = {16'b0, target_r};
      REG_FIXED_DELTA: cfg_prdata = {12'b0, fixed_delta_r};
      REG_WARMUP:      cfg_prdata = {24'b0, warmup_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // frame count and period guard
  always_comb begin
    warm_cap  = {1'b0, warmup_r} + 9'd1;
    frame_cnt = (frames_r + 9'd1 > warm_cap) ? warm_cap : frames_r + 9'd1;
    meas_d    = in_data.time_us - last_time_r;
    meas_delta = (meas_d > 32'(DELTA_MIN) && meas_d < DELTA_LIMIT) ? meas_d[19:0]
                                                                  : fixed_delta_r;
  end

  // rate ceiling floor(target * 21 / 20), and instant rate clamps
  always_comb begin
    tgt_x21     = {1'b0, target_r, 4'b0} + {3'b0, target_r, 2'b0} + {5'b0, target_r};
    tgt_q4      = tgt_x21[20:2];
    hi_prod_nxt = (2*HI_MUL_W)'(tgt_q4) * (2*HI_MUL_W)'(HI_RECIP);
    rate_hi_lim = hi_prod_r[HI_SHIFT +: HI_W];

    delta_small = (delta_r <= DELTA_MIN);
    rate_lo = (div_quo < DIV_W'(RATE_FLOOR)) ? DIV_W'(RATE_FLOOR) : div_quo;
    rate_cl = (rate_lo > DIV_W'(rate_hi_lim)) ? DIV_W'(rate_hi_lim) : rate_lo;
    if (delta_small) begin
      inst_rate = target_r;
    end else if (rate_cl > DIV_W'(RATE_SAT)) begin
      inst_rate = RATE_SAT;
    end else begin
      inst_rate = rate_cl[15:0];
    end

    mean_rate = (div_quo > DIV_W'(target_r)) ? target_r : div_quo[15:0];
    ring_full = (cnt_r == CNT_W'(SAMPLES));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    frames_nxt    = frames_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    delta_nxt     = delta_r;
    rate_nxt      = rate_r;
    warm_nxt      = warm_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dsr       = '0;
    ring_re       = 1'b0;
    ring_we       = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_time_nxt = in_data.time_us;
          if (in_data.req_type == REQ_RESET) begin
            frames_nxt = '0;
            slot_nxt   = '0;
            cnt_nxt    = '0;
            sum_nxt    = '0;
            rate_nxt   = target_r;
            warm_nxt   = 1'b1;
            state_nxt  = ST_FIN;
          end else begin
            frames_nxt = frame_cnt;
            if (frame_cnt <= {1'b0, warmup_r}) begin
              delta_nxt = fixed_delta_r;
              rate_nxt  = target_r;
              warm_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              delta_nxt = meas_delta;
              warm_nxt  = 1'b0;
              state_nxt = ST_MEAS;
            end
          end
        end
      end
      ST_MEAS: begin
        ring_re = 1'b1;
        if (delta_small) begin
          state_nxt = ST_PUSH;
        end else begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(RATE_NUM);
          div_dsr   = delta_r;
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_sts.done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // oldest sample leaves the sum once the ring is full
        ring_we = 1'b1;
        sum_nxt = sum_r - (ring_full ? SUM_W'(ring_rd_r) : SUM_W'(0)) + SUM_W'(inst_rate);
        cnt_nxt = ring_full ? cnt_r : cnt_r + CNT_W'(1);
        slot_nxt = (slot_r == SLOT_W'(SAMPLES - 1)) ? '0 : slot_r + SLOT_W'(1);
        div_start = 1'b1;
        div_dvd   = DIV_W'(sum_nxt);
        div_dsr   = DSR_W'(cnt_nxt);
        state_nxt = ST_DIVM;
      end
      ST_DIVM: begin
        if (div_sts.done) begin
          rate_nxt  = mean_rate;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load | (out_valid_r & out_stall);
    out_data_nxt  = out_load ? {delta_r, rate_r, warm_r} : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_time_r <= '0;
      frames_r    <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      delta_r     <= FIXED_DELTA_RST;
      rate_r      <= TARGET_RST;
      warm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_time_r <= last_time_nxt;
      frames_r    <= frames_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      delta_r     <= delta_nxt;
      rate_r      <= rate_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (state_r == ST_MEAS) begin
      hi_prod_r <= hi_prod_nxt;
    end
  end

  // sample ring, registered read of the slot about to be overwritten
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= inst_rate;
    end
    if (ring_re) begin
      ring_rd_r <= ring_mem[slot_r];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sample count never passes the ring depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SAMPLES))
    else $error("sample count above ring depth");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIVR || state_r == ST_DIVM))
    else $error("divider result with no waiting state");

  // a new result is only loaded from the final state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside final state");

endmodule

// ===== test/frame_rate_meter_tb.sv =====
// frame_rate_meter_tb: self-checking testbench of the frame rate meter
// depends on frm_pkg and frame_rate_meter; predicts each result from its own model
// of the period guard, rate clamp and sample ring, under random bursts and stalls

module frame_rate_meter_tb
  import frm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  frm_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  frm_out_t              out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  frame_rate_meter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // meter settings as last written
  logic [15:0] tgt_q8 = TARGET_RST;
  logic [19:0] fb_delta = FIXED_DELTA_RST;
  logic [7:0]  warm_frames = WARMUP_RST;

  // meter state
  logic [31:0] last_stamp = '0;
  int unsigned frame_count = 0;
  logic [15:0] rate_ring [RING_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_fill = 0;
  int unsigned ring_sum = 0;
  logic [19:0] held_delta = FIXED_DELTA_RST;
  logic [15:0] held_rate = TARGET_RST;

  frm_in_t  pending_events [$];
  frm_out_t expected_reports [$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  logic [31:0] stamp_now = '0;

  function automatic logic [15:0] instant_rate_of(logic [19:0] period);
    int unsigned rate;
    int unsigned ceiling;
    if (period <= 20'd100) return tgt_q8;
    rate = 32'd256000000 / 32'(period);
    ceiling = (32'(tgt_q8) * 21) / 20;
    if (rate < 256) rate = 256;
    if (rate > ceiling) rate = ceiling;
    if (rate > 65535) rate = 65535;
    return rate[15:0];
  endfunction

  function automatic frm_out_t meter_step(frm_in_t ev);
    frm_out_t rep;
    int unsigned cnt;
    int unsigned mean;
    logic [31:0] period;
    logic [15:0] rate;
    rep.in_warmup = 1'b0;
    if (ev.req_type == REQ_RESET) begin
      frame_count = 0;
      ring_wr = 0;
      ring_fill = 0;
      ring_sum = 0;
      held_rate = tgt_q8;
      rep.in_warmup = 1'b1;
    end else begin
      cnt = frame_count + 1;
      if (cnt > 32'(warm_frames) + 1) cnt = 32'(warm_frames) + 1;
      frame_count = cnt;
      if (cnt <= 32'(warm_frames)) begin
        held_delta = fb_delta;
        held_rate = tgt_q8;
        rep.in_warmup = 1'b1;
      end else begin
        period = ev.time_us - last_stamp;
        held_delta = (period > 100 && period < 1000000) ? period[19:0] : fb_delta;
        rate = instant_rate_of(held_delta);
        // ring full: the oldest sample drops out of the sum
        if (ring_fill >= RING_DEPTH) ring_sum -= 32'(rate_ring[ring_wr]);
        else ring_fill++;
        rate_ring[ring_wr] = rate;
        ring_sum += 32'(rate);
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        mean = ring_sum / ring_fill;
        if (mean > 32'(tgt_q8)) mean = 32'(tgt_q8);
        held_rate = mean[15:0];
      end
    end
    last_stamp = ev.time_us;
    rep.delta_time_us = held_delta;
    rep.current_fps_q8 = held_rate;
    return rep;
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_reports.push_back(meter_step(in_data));
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_events.size() > 0) begin
        in_data <= pending_events.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in segments, plus one long hold-off
  int unsigned stall_seg = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_seen >= 100) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (stall_seg == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_seg <= $urandom_range(20, 200);
      end else begin
        stall_seg <= stall_seg - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    frm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen <= reports_seen + 1;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (out_data.delta_time_us !== want.delta_time_us) begin
          $display("%0t delta_time_us: expected %0d, actual %0d", $time,
                   want.delta_time_us, out_data.delta_time_us);
          mismatches++;
        end
        if (out_data.current_fps_q8 !== want.current_fps_q8) begin
          $display("%0t current_fps_q8: expected %0d, actual %0d", $time,
                   want.current_fps_q8, out_data.current_fps_q8);
          mismatches++;
        end
        if (out_data.in_warmup !== want.in_warmup) begin
          $display("%0t in_warmup: expected %0d, actual %0d", $time,
                   want.in_warmup, out_data.in_warmup);
          mismatches++;
        end
      end
    end
  end

  task automatic add_event(logic req, logic [31:0] stamp);
    frm_in_t ev;
    ev.req_type = req;
    ev.time_us = stamp;
    pending_events.push_back(ev);
  endtask

  task automatic add_frame_after(logic [31:0] period);
    stamp_now += period;
    add_event(REQ_FRAME, stamp_now);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_TARGET: tgt_q8 = value[15:0];
      REG_FIXED_DELTA: fb_delta = value[19:0];
      REG_WARMUP: warm_frames = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_events.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly plausible frame periods, some guard violations, resets and garbage stamps
  task automatic add_random_frames(int unsigned n, int unsigned reset_pct);
    int unsigned k;
    int unsigned pick;
    logic [31:0] period;
    int unsigned guard_pts [4];
    guard_pts = '{100, 101, 999999, 1000000};
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < reset_pct) begin
        if ($urandom_range(0, 1) == 0) stamp_now = $urandom();
        add_event(REQ_RESET, stamp_now);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) period = $urandom_range(101, 40000);
        else if (pick < 75) period = $urandom_range(101, 999999);
        else if (pick < 83) period = $urandom_range(0, 100);
        else if (pick < 88) period = $urandom_range(1000000, 32'hFFFF_FFFF);
        else if (pick < 94) period = guard_pts[$urandom_range(0, 3)];
        else period = $urandom();
        add_frame_after(period);
      end
    end
  endtask

  task automatic run_phase(logic [15:0] tgt, logic [19:0] fb, logic [7:0] wf,
                           int unsigned n, int unsigned reset_pct);
    wait_idle();
    cfg_write(REG_TARGET, 32'(tgt));
    cfg_write(REG_FIXED_DELTA, 32'(fb));
    cfg_write(REG_WARMUP, 32'(wf));
    stamp_now = $urandom();
    add_random_frames(n, reset_pct);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up frames at the stamp extremes, then a measured period across the wrap
    add_event(REQ_FRAME, 32'h0000_0000);
    add_event(REQ_FRAME, 32'hFFFF_FFF0);
    stamp_now = 32'hFFFF_FFFF;
    add_event(REQ_FRAME, stamp_now);
    add_frame_after(32'd16666);
    // guard edges, zero period, slow and huge periods
    add_frame_after(32'd100);
    add_frame_after(32'd101);
    add_frame_after(32'd999999);
    add_frame_after(32'd1000000);
    add_frame_after(32'd0);
    add_frame_after(32'd33333);
    add_frame_after(32'd4000000);
    add_event(REQ_RESET, 32'hA5A5_5A5A);
    add_event(REQ_RESET, 32'h5A5A_A5A5);
    stamp_now = 32'h5A5A_A5A5;
    add_frame_after(32'd16667);
    add_frame_after(32'd16667);
    add_frame_after(32'd16667);
    add_frame_after(32'd8333);
    add_frame_after(32'd20000);

    run_phase(16'd61440, 20'd999999, 8'd0, 250, 3);
    run_phase(16'd256, 20'd101, 8'd255, 300, 0);
    run_phase(16'($urandom_range(256, 61440)), 20'($urandom_range(101, 999999)),
              8'($urandom_range(0, 8)), 250, 3);
    // target below the rate floor and a fallback period inside the guard band
    run_phase(16'd100, 20'd50, 8'd1, 150, 4);
    // full-scale target saturates the stored samples, zero fallback period
    run_phase(16'd65535, 20'd0, 8'd2, 120, 4);
    run_phase(TARGET_RST, FIXED_DELTA_RST, WARMUP_RST, 160, 3);
    run_phase(16'($urandom_range(256, 61440)), 20'($urandom_range(101, 999999)),
              8'($urandom_range(0, 8)), 200, 3);

    wait_idle();
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[frame_rate_meter] OK");
    end else begin
      $display("[frame_rate_meter] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[frame_rate_meter] ERROR");
    $finish;
  end

endmodule
